>>> sv/rrbg_pkg.sv
`timescale 1ns / 1ps

package rrbg_pkg;

  localparam int WORD_W  = 64;
  localparam int LEN_W   = 17;
  localparam int BUDGET_W = 8;
  localparam int CFG_ADDR_W = 2;

  // register indexes of the configuration port
  localparam logic [CFG_ADDR_W-1:0] CFG_RECORD_LENGTH = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BIT_BUDGET    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ASCII_MODE    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_START_SEED    = 2'd3;

  localparam logic [LEN_W-1:0]    RST_RECORD_LENGTH = 17'd16;
  localparam logic [BUDGET_W-1:0] RST_BIT_BUDGET    = 8'd128;
  localparam logic [WORD_W-1:0]   RST_START_SEED    = 64'd1;

  // xoroshiro128+ rotation and shift amounts
  localparam int ROT_A = 24;
  localparam int ROT_B = 37;
  localparam int SHL_C = 16;

  localparam logic [BUDGET_W-1:0] UNIFORM_BUDGET = 8'd128;
  localparam logic [BUDGET_W-1:0] HALF_BUDGET    = 8'd64;

  localparam logic [7:0] CHAR_NL     = 8'h0a;
  localparam logic [7:0] CHAR_DIGIT0 = 8'h30;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [WORD_W-1:0] s0;
    logic [WORD_W-1:0] s1;
  } gen_t;

  // one queued byte job: generator state to draw from, byte kind and last flag
  typedef struct packed {
    gen_t src;
    logic ascii;
    logic last;
  } job_t;

endpackage

>>> sv/random_record_byte_generator_top.sv
`timescale 1ns / 1ps

// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------
// in        | in_valid / in_ready  | in_restart
// out       | out_valid / out_ready| out_data_byte, out_last_of_record
// cfg       | cfg_we               | cfg_addr, cfg_wdata
//
// one beat in and one byte out per cycle unless the queue is full or the
// receiver stalls; secondary reseeding at a record start adds no stall
// an accepted beat is held in the queue, then registered in the draw adder,
// digit sum and output registers of the back end
// a four-entry queue parts front and back; in_ready drops only when it is full
// reset is synchronous, active low; no clearing pass

module random_record_byte_generator_top #(
  parameter int MAX_RECORD_BYTES = 65536
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rrbg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rrbg_pkg::WORD_W-1:0]     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_restart,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_data_byte,
  output logic                            out_last_of_record
);

  logic           push_valid, push_ready;
  rrbg_pkg::job_t push_job;
  logic           pop_valid, pop_ready;
  rrbg_pkg::job_t pop_job;

  rrbg_front #(
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  rrbg_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  rrbg_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .pop_job            (pop_job),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_data_byte      (out_data_byte),
    .out_last_of_record (out_last_of_record)
  );

endmodule

>>> sv/rrbg_front.sv
`timescale 1ns / 1ps

module rrbg_front #(
  parameter int MAX_RECORD_BYTES = 65536
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [rrbg_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [rrbg_pkg::WORD_W-1:0]          cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_restart,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output rrbg_pkg::job_t                       push_job
);

  localparam int POS_W = $clog2(MAX_RECORD_BYTES);
  localparam logic [rrbg_pkg::LEN_W-1:0] MAX_LEN = rrbg_pkg::LEN_W'(MAX_RECORD_BYTES);
  localparam logic [rrbg_pkg::LEN_W-1:0] MIN_LEN = rrbg_pkg::LEN_W'(2);

  function automatic rrbg_pkg::gen_t xr_step(input rrbg_pkg::gen_t g);
    rrbg_pkg::gen_t n;
    logic [rrbg_pkg::WORD_W-1:0] b;
    b    = g.s1 ^ g.s0;
    n.s0 = ((g.s0 << rrbg_pkg::ROT_A) | (g.s0 >> (rrbg_pkg::WORD_W - rrbg_pkg::ROT_A)))
           ^ b ^ (b << rrbg_pkg::SHL_C);
    n.s1 = (b << rrbg_pkg::ROT_B) | (b >> (rrbg_pkg::WORD_W - rrbg_pkg::ROT_B));
    return n;
  endfunction

  function automatic rrbg_pkg::gen_t seed_gen(input logic [rrbg_pkg::WORD_W-1:0] s);
    rrbg_pkg::gen_t g;
    g.s0 = s;
    g.s1 = '0;
    return xr_step(xr_step(g));
  endfunction

  logic [rrbg_pkg::LEN_W-1:0]    record_length_r;
  logic [rrbg_pkg::BUDGET_W-1:0] bit_budget_r;
  logic                          ascii_mode_r;
  logic [rrbg_pkg::WORD_W-1:0]   start_seed_r;

  rrbg_pkg::gen_t main_r, main_nxt;
  rrbg_pkg::gen_t aux_r, aux_nxt;
  logic           use_aux_r, use_aux_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  logic [rrbg_pkg::LEN_W-1:0]    len_eff;
  logic [rrbg_pkg::BUDGET_W-1:0] budget_eff;
  logic [POS_W-1:0]              pos0;
  logic [rrbg_pkg::LEN_W-1:0]    pos_inc;
  logic                          last;
  logic                          start;
  logic                          uniform;
  logic                          wide;
  logic                          seeding;
  logic                          use_cur;
  logic                          take_draw;
  logic [6:0]                    sh_full;
  logic [5:0]                    sh;
  logic [rrbg_pkg::WORD_W-1:0]   sum0, sum1, shifted;
  rrbg_pkg::gen_t                main_pre, step1, step2, aux_seed, aux_fresh;
  rrbg_pkg::gen_t                main_cur, aux_cur, src, src_next;
  logic                          accept;

  assign accept     = in_valid && in_ready;
  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    len_eff = record_length_r;
    if (len_eff < MIN_LEN) len_eff = MIN_LEN;
    if (len_eff > MAX_LEN) len_eff = MAX_LEN;
    budget_eff = (bit_budget_r == '0) ? rrbg_pkg::BUDGET_W'(1) : bit_budget_r;
  end

  assign pos0    = in_restart ? '0 : pos_r;
  assign pos_inc = rrbg_pkg::LEN_W'(pos0) + rrbg_pkg::LEN_W'(1);
  assign last    = (pos_inc >= len_eff);
  assign start   = (pos0 == '0);
  assign uniform = (budget_eff >= rrbg_pkg::UNIFORM_BUDGET) ||
                   ({12'd0, budget_eff} >= {len_eff, 3'b000});
  assign wide    = (budget_eff > rrbg_pkg::HALF_BUDGET);

  // 64 - budget, which is also 128 - budget modulo 64 for wide budgets
  assign sh_full = 7'd64 - budget_eff[6:0];
  assign sh      = sh_full[5:0];

  // reseed a secondary generator from one or two main draws
  always_comb begin
    main_pre = in_restart ? seed_gen(start_seed_r) : main_r;
    step1    = xr_step(main_pre);
    step2    = xr_step(step1);
    sum0     = main_pre.s0 + main_pre.s1;
    sum1     = step1.s0 + step1.s1;
    shifted  = (wide ? sum1 : sum0) >> sh;
    aux_seed.s0 = wide ? sum0 : shifted;
    aux_seed.s1 = wide ? shifted : '0;
    aux_fresh   = xr_step(xr_step(aux_seed));
  end

  assign seeding   = start && !uniform;
  assign use_cur   = start ? !uniform : use_aux_r;
  assign take_draw = !(ascii_mode_r && last);

  always_comb begin
    main_cur = seeding ? (wide ? step2 : step1) : main_pre;
    aux_cur  = seeding ? aux_fresh : aux_r;
    src      = use_cur ? aux_cur : main_cur;
    src_next = xr_step(src);
    main_nxt = (take_draw && !use_cur) ? src_next : main_cur;
    aux_nxt  = (take_draw && use_cur) ? src_next : aux_cur;
    use_aux_nxt = use_cur;
    pos_nxt  = last ? '0 : pos_inc[POS_W-1:0];
  end

  assign push_job.src   = src;
  assign push_job.ascii = ascii_mode_r;
  assign push_job.last  = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_length_r <= rrbg_pkg::RST_RECORD_LENGTH;
      bit_budget_r    <= rrbg_pkg::RST_BIT_BUDGET;
      ascii_mode_r    <= 1'b0;
      start_seed_r    <= rrbg_pkg::RST_START_SEED;
    end else if (cfg_we) begin
      case (cfg_addr)
        rrbg_pkg::CFG_RECORD_LENGTH: record_length_r <= cfg_wdata[rrbg_pkg::LEN_W-1:0];
        rrbg_pkg::CFG_BIT_BUDGET:    bit_budget_r    <= cfg_wdata[rrbg_pkg::BUDGET_W-1:0];
        rrbg_pkg::CFG_ASCII_MODE:    ascii_mode_r    <= cfg_wdata[0];
        rrbg_pkg::CFG_START_SEED:    start_seed_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_r    <= seed_gen(rrbg_pkg::RST_START_SEED);
      aux_r     <= '0;
      use_aux_r <= 1'b0;
      pos_r     <= '0;
    end else if (accept) begin
      main_r    <= main_nxt;
      aux_r     <= aux_nxt;
      use_aux_r <= use_aux_nxt;
      pos_r     <= pos_nxt;
    end
  end

endmodule

>>> sv/rrbg_fifo.sv
`timescale 1ns / 1ps

module rrbg_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  rrbg_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rrbg_pkg::job_t pop_job
);

  rrbg_pkg::job_t mem_r [rrbg_pkg::FIFO_DEPTH];
  logic [rrbg_pkg::FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [rrbg_pkg::FIFO_CNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign push_ready = (count_r != rrbg_pkg::FIFO_CNT_W'(rrbg_pkg::FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + rrbg_pkg::FIFO_CNT_W'(1);
    if (!do_push && do_pop) count_nxt = count_r - rrbg_pkg::FIFO_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + rrbg_pkg::FIFO_PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + rrbg_pkg::FIFO_PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

>>> sv/rrbg_back.sv
`timescale 1ns / 1ps

module rrbg_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  rrbg_pkg::job_t pop_job,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_data_byte,
  output logic           out_last_of_record
);

  localparam int DRAW_W = rrbg_pkg::WORD_W - 4;
  localparam int CHUNKS = DRAW_W / 6;

  // 64 is 1 mod 9, so the six-bit digits sum to the same residue
  function automatic logic [9:0] digit_sum(input logic [DRAW_W-1:0] r);
    logic [9:0] acc;
    acc = '0;
    for (int i = 0; i < CHUNKS; i++) acc = acc + 10'(r[6*i +: 6]);
    return acc;
  endfunction

  function automatic logic [7:0] alnum(input logic [9:0] s, input logic [1:0] m4);
    logic [6:0] t;
    logic [5:0] u;
    logic [4:0] v;
    logic [3:0] m9;
    logic [1:0] k;
    logic [5:0] x;
    t  = 7'(s[9:6]) + 7'(s[5:0]);
    u  = 6'(7'(t[6]) + 7'(t[5:0]));
    // 8 is -1 mod 9
    v  = 5'(u[2:0]) - 5'(u[5:3]);
    m9 = v[4] ? 4'(v + 5'd9) : v[3:0];
    // pick x = m9 + 9k with x matching the residue mod 4
    k  = m4 - m9[1:0];
    x  = 6'(m9) + 6'({k, 3'b000}) + 6'(k);
    if (x < 6'd10) return rrbg_pkg::CHAR_DIGIT0 + 8'(x);
    return rrbg_pkg::CHAR_LOWER_A + 8'(x - 6'd10);
  endfunction

  logic en;
  logic a_valid_r, b_valid_r, out_valid_r;
  logic [DRAW_W-1:0] a_draw_r;
  logic a_ascii_r, a_last_r;
  logic [9:0] b_dsum_r;
  logic [1:0] b_m4_r;
  logic [7:0] b_raw_r;
  logic b_ascii_r, b_last_r;
  logic [7:0] out_data_r, out_data_nxt;
  logic out_last_r;
  logic [rrbg_pkg::WORD_W-1:0] sum;

  assign en        = !out_valid_r || out_ready;
  assign pop_ready = en;
  assign sum       = pop_job.src.s0 + pop_job.src.s1;

  always_comb begin
    if (b_ascii_r && b_last_r) out_data_nxt = rrbg_pkg::CHAR_NL;
    else if (b_ascii_r)        out_data_nxt = alnum(b_dsum_r, b_m4_r);
    else                       out_data_nxt = b_raw_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r   <= pop_valid;
      b_valid_r   <= a_valid_r;
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_draw_r   <= sum[rrbg_pkg::WORD_W-1:4];
      a_ascii_r  <= pop_job.ascii;
      a_last_r   <= pop_job.last;
      b_dsum_r   <= digit_sum(a_draw_r);
      b_m4_r     <= a_draw_r[1:0];
      b_raw_r    <= a_draw_r[7:0];
      b_ascii_r  <= a_ascii_r;
      b_last_r   <= a_last_r;
      out_data_r <= out_data_nxt;
      out_last_r <= b_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data_byte      = out_data_r;
  assign out_last_of_record = out_last_r;

endmodule

>>> tb/sv/tb_random_record_byte_generator_top.sv
`timescale 1ns / 1ps

// tracks the generator state one beat ahead of the block and holds the bytes still owed
class record_byte_predictor;
  logic [63:0] main_s0, main_s1;
  logic [63:0] aux_s0, aux_s1;
  bit          from_aux;
  logic [15:0] pos;
  logic [16:0] rec_len;
  logic [7:0]  budget;
  bit          ascii;
  logic [63:0] seed;

  logic [7:0] exp_byte[$];
  bit         exp_last[$];

  int mismatches;
  int bytes_checked;
  int records_done;
  int aux_records;

  function new();
    rec_len = rrbg_pkg::RST_RECORD_LENGTH;
    budget = rrbg_pkg::RST_BIT_BUDGET;
    ascii = 1'b0;
    seed = rrbg_pkg::RST_START_SEED;
    aux_s0 = '0;
    aux_s1 = '0;
    from_aux = 1'b0;
    pos = '0;
    mismatches = 0;
    bytes_checked = 0;
    records_done = 0;
    aux_records = 0;
    reseed_main();
  endfunction

  // one xoroshiro128+ step, returns the sum of the old words
  function logic [63:0] advance(inout logic [63:0] s0, inout logic [63:0] s1);
    logic [63:0] a, b, sum;
    a = s0;
    b = s1;
    sum = a + b;
    b = b ^ a;
    s0 = ((a << rrbg_pkg::ROT_A) | (a >> (64 - rrbg_pkg::ROT_A))) ^ b ^ (b << rrbg_pkg::SHL_C);
    s1 = (b << rrbg_pkg::ROT_B) | (b >> (64 - rrbg_pkg::ROT_B));
    return sum;
  endfunction

  function void reseed_main();
    main_s0 = seed;
    main_s1 = '0;
    void'(advance(main_s0, main_s1));
    void'(advance(main_s0, main_s1));
  endfunction

  function int clamped_length();
    int l;
    l = int'(rec_len);
    if (l < 2) l = 2;
    if (l > 65536) l = 65536;
    return l;
  endfunction

  function void open_record(input int len);
    int b;
    b = int'(budget);
    if (b == 0) b = 1;
    if (b >= 128 || b >= 8 * len) begin
      from_aux = 1'b0;
      return;
    end
    if (b > 64) begin
      aux_s0 = advance(main_s0, main_s1);
      aux_s1 = advance(main_s0, main_s1) >> (128 - b);
    end else begin
      aux_s0 = advance(main_s0, main_s1) >> (64 - b);
      aux_s1 = '0;
    end
    void'(advance(aux_s0, aux_s1));
    void'(advance(aux_s0, aux_s1));
    from_aux = 1'b1;
    aux_records++;
  endfunction

  function void write_reg(input logic [rrbg_pkg::CFG_ADDR_W-1:0] idx, input logic [63:0] val);
    case (idx)
      rrbg_pkg::CFG_RECORD_LENGTH: rec_len = val[16:0];
      rrbg_pkg::CFG_BIT_BUDGET:    budget = val[7:0];
      rrbg_pkg::CFG_ASCII_MODE:    ascii = val[0];
      rrbg_pkg::CFG_START_SEED:    seed = val;
      default: ;
    endcase
  endfunction

  function void note_request(input bit restart);
    int len;
    int p;
    bit last;
    logic [63:0] r;
    logic [7:0] val;
    len = clamped_length();
    if (restart) begin
      reseed_main();
      pos = '0;
    end
    if (pos == 0) open_record(len);
    last = (int'(pos) + 1 >= len);
    if (ascii && last) begin
      val = rrbg_pkg::CHAR_NL;
    end else begin
      if (from_aux) r = advance(aux_s0, aux_s1) >> 4;
      else r = advance(main_s0, main_s1) >> 4;
      if (ascii) begin
        p = int'(r % 36);
        val = (p < 10) ? rrbg_pkg::CHAR_DIGIT0 + 8'(p) : rrbg_pkg::CHAR_LOWER_A + 8'(p - 10);
      end else begin
        val = r[7:0];
      end
    end
    pos = last ? 16'd0 : pos + 16'd1;
    exp_byte.push_back(val);
    exp_last.push_back(last);
  endfunction

  function void check_byte(input logic [7:0] data, input logic last_flag);
    logic [7:0] want;
    bit want_last;
    if (exp_byte.size() == 0) begin
      $display("%0t: unexpected beat: data_byte %h last_of_record %b", $time, data, last_flag);
      mismatches++;
      return;
    end
    want = exp_byte.pop_front();
    want_last = exp_last.pop_front();
    if (data !== want) begin
      $display("%0t: data_byte expected %h actual %h", $time, want, data);
      mismatches++;
    end
    if (last_flag !== want_last) begin
      $display("%0t: last_of_record expected %b actual %b", $time, want_last, last_flag);
      mismatches++;
    end
    bytes_checked++;
    if (want_last) records_done++;
  endfunction

  function int pending();
    return exp_byte.size();
  endfunction
endclass

module tb_random_record_byte_generator_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1950;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [rrbg_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [rrbg_pkg::WORD_W-1:0]     cfg_wdata;
  logic                            in_valid;
  logic                            in_ready;
  logic                            in_restart;
  logic                            out_valid;
  logic                            out_ready;
  logic [7:0]                      out_data_byte;
  logic                            out_last_of_record;

  record_byte_predictor predictor = new();
  bit hold_request;
  int cycles;
  int restarts;
  int reg_writes;

  random_record_byte_generator_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data_byte     (out_data_byte),
    .out_last_of_record(out_last_of_record)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still owed", cycles, predictor.pending());
      $display("tb_random_record_byte_generator_top NOT OK");
      $finish;
    end
  end

  // receiver: ready and stall runs of random length, plus a long hold on request
  initial begin : sink
    int run_left;
    int hold_left;
    bit rdy;
    run_left = 0;
    hold_left = 0;
    rdy = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready)
        predictor.check_byte(out_data_byte, out_last_of_record);
      if (hold_request) begin
        hold_left = 120;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (run_left == 0) begin
          rdy = !rdy;
          if (rdy)
            run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 10);
          else
            run_left = $urandom_range(1, 5);
        end
        run_left--;
      end
      out_ready <= rdy;
    end
  end

  task automatic push_request(input bit restart);
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_ready !== 1'b1);
    predictor.note_request(restart);
    if (restart) restarts++;
  endtask

  task automatic send_stream(input int n, input bit first_restart, input bit gaps);
    int burst;
    int k;
    int i;
    burst = 0;
    for (i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        k = gaps ? $urandom_range(0, 8) : 0;
        if (k > 0) begin
          in_valid <= 1'b0;
          repeat (k) @(posedge clk);
        end
      end
      burst--;
      push_request((i == 0) ? first_restart : ($urandom_range(0, 99) < 3));
    end
  endtask

  // stop offering beats and wait for every owed byte, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (predictor.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_one(input logic [rrbg_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    predictor.write_reg(idx, val);
    reg_writes++;
  endtask

  task automatic program_regs(input logic [3:0] mask, input logic [63:0] len_w,
                              input logic [63:0] bud_w, input logic [63:0] asc_w,
                              input logic [63:0] seed_w);
    if (mask[0]) write_one(rrbg_pkg::CFG_RECORD_LENGTH, len_w);
    if (mask[1]) write_one(rrbg_pkg::CFG_BIT_BUDGET, bud_w);
    if (mask[2]) write_one(rrbg_pkg::CFG_ASCII_MODE, asc_w);
    if (mask[3]) write_one(rrbg_pkg::CFG_START_SEED, seed_w);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int phase;
    int items;
    int n;
    int eff;
    int cap;
    logic [16:0] len;
    logic [7:0] bud;
    logic [63:0] len_w, bud_w, asc_w, seed_w;
    logic [3:0] mask;
    bit gaps;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_restart <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= rrbg_pkg::CFG_RECORD_LENGTH;
    cfg_wdata <= '0;
    hold_request = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings first, then a restart
    push_request(1'b0);
    push_request(1'b0);
    push_request(1'b1);
    push_request(1'b0);
    drain();
    // length below two, zero budget, ascii, zero seed
    program_regs(4'hf, 64'd0, 64'd0, 64'd1, 64'd0);
    push_request(1'b1);
    repeat (3) push_request(1'b0);
    drain();
    // length beyond the maximum, budget above half, all-ones seed
    program_regs(4'hf, 64'h1ffff, 64'd127, 64'd0, '1);
    push_request(1'b1);
    repeat (3) push_request(1'b0);
    drain();
    // shrink the length mid-record: this beat must close the record
    program_regs(4'h1, 64'd1, 64'd0, 64'd0, 64'd0);
    push_request(1'b0);
    drain();
    program_regs(4'h3, 64'd9, 64'd64, 64'd0, 64'd0);
    repeat (3) push_request(1'b0);
    drain();
    // switch to ascii mid-record
    program_regs(4'h4, 64'd0, 64'd0, 64'd1, 64'd0);
    repeat (2) push_request(1'b0);
    drain();
    // new seed and uniform budget without restart, then budget above range
    program_regs(4'ha, 64'd0, 64'd128, 64'd0, {$urandom, $urandom});
    repeat (5) push_request(1'b0);
    drain();
    program_regs(4'h2, 64'd0, 64'd255, 64'd0, 64'd0);
    push_request(1'b1);

    phase = 0;
    items = 0;
    while (items < RANDOM_ITEMS) begin
      drain();
      case ($urandom_range(0, 19))
        0, 1:    len = 17'($urandom_range(0, 1));
        2:       len = 17'($urandom_range(301, 65536));
        3:       len = 17'($urandom_range(65537, 131071));
        4, 5:    len = 17'($urandom_range(25, 300));
        default: len = 17'($urandom_range(2, 24));
      endcase
      eff = (len < 2) ? 2 : ((len > 65536) ? 65536 : int'(len));
      cap = (8 * eff - 1 > 127) ? 127 : 8 * eff - 1;
      case ($urandom_range(0, 9))
        0:       bud = 8'($urandom);
        1:       bud = rrbg_pkg::UNIFORM_BUDGET;
        default: bud = 8'($urandom_range(0, cap));
      endcase
      // upper bits of the write data are junk now and then
      len_w = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
      len_w[16:0] = len;
      bud_w = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
      bud_w[7:0] = bud;
      asc_w = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
      asc_w[0] = $urandom_range(0, 2) == 0;
      case ($urandom_range(0, 7))
        0:       seed_w = '0;
        1:       seed_w = '1;
        default: seed_w = {$urandom, $urandom};
      endcase
      mask = (phase == 0) ? 4'hf : 4'($urandom_range(1, 15));
      program_regs(mask, len_w, bud_w, asc_w, seed_w);

      gaps = (phase % 3) != 0;
      if (phase == 4) begin
        // receiver holds off while beats keep coming, so the queue fills
        n = $urandom_range(60, 140);
        send_stream(n / 2, 1'($urandom_range(0, 1)), 1'b0);
        hold_request = 1'b1;
        send_stream(n - n / 2, 1'b0, 1'b0);
      end else if (phase == 7) begin
        n = $urandom_range(40, 140);
        send_stream(n / 2, 1'($urandom_range(0, 1)), gaps);
        drain();
        send_stream(n - n / 2, 1'b0, gaps);
      end else begin
        n = $urandom_range(20, 140);
        send_stream(n, 1'($urandom_range(0, 1)), gaps);
      end
      items += n;
      phase++;
    end
    drain();
    repeat (10) @(posedge clk);

    $display("checked %0d bytes over %0d finished records (%0d from the secondary generator)",
             predictor.bytes_checked, predictor.records_done, predictor.aux_records);
    $display("%0d register writes across %0d settings, %0d restarts", reg_writes, phase + 8,
             restarts);
    if (predictor.mismatches == 0 && predictor.pending() == 0) begin
      $display("tb_random_record_byte_generator_top OK");
    end else begin
      $display("tb_random_record_byte_generator_top NOT OK");
    end
    $finish;
  end

endmodule
